// ----- rtl/slm_pkg.sv -----
// shared types and constants for the sorted list merge block
package slm_pkg;

	localparam int VALUE_W = 32;
	localparam int OP_W    = 2;
	localparam int STAT_W  = 2;

	localparam logic [OP_W-1:0] OP_APPEND_A = 2'd0;
	localparam logic [OP_W-1:0] OP_APPEND_B = 2'd1;
	localparam logic [OP_W-1:0] OP_MERGE    = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_ORDER = 2'd2;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd3;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_FETCH,
		ST_MERGE
	} state_t;

endpackage

// ----- rtl/slm_in_if.sv -----
// command channel: operation and value
interface slm_in_if;
	logic                                 valid;
	logic                                 ready;
	logic [slm_pkg::OP_W-1:0]             operation;
	logic signed [slm_pkg::VALUE_W-1:0]   value;

	modport source (output valid, output operation, output value, input ready);
	modport sink   (input valid, input operation, input value, output ready);
endinterface

// ----- rtl/slm_out_if.sv -----
// result channel: merged value, status and last flag
interface slm_out_if;
	logic                                 valid;
	logic                                 ready;
	logic signed [slm_pkg::VALUE_W-1:0]   value_res;
	logic [slm_pkg::STAT_W-1:0]           status;
	logic                                 last;

	modport source (output valid, output value_res, output status, output last, input ready);
	modport sink   (input valid, input value_res, input status, input last, output ready);
endinterface

// ----- rtl/sorted_list_merge.sv -----
// top level: two sorted lists in ram, merged by a shared signed comparator
//
//   channel | dir | payload                       | handshake
//   cmd     | in  | operation, value              | valid / ready
//   rsp     | out | value_res, status, last       | valid / ready
//
// append: taken in idle, one result lands in the output register
// merge: accept, ram fetch state, then one value per cycle unless rsp stalls;
//   the single signed comparator and the registered ram read set this pace
// reset clears list counts, sequencer and output valid; list ram is not cleared
// a stalled rsp holds its result and pauses the merge walk
module sorted_list_merge #(
	parameter int LIST_DEPTH = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	slm_in_if.sink          cmd,
	slm_out_if.source       rsp
);

	localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
	localparam int CW = $clog2(LIST_DEPTH + 1);

	slm_pkg::state_t state_q, state_d;

	logic [CW-1:0] count_a_q, count_a_d;
	logic [CW-1:0] count_b_q, count_b_d;
	logic [CW-1:0] ia_q, ia_d;
	logic [CW-1:0] ib_q, ib_d;

	logic signed [slm_pkg::VALUE_W-1:0] last_a_q, last_b_q;
	logic                               last_a_ld, last_b_ld;

	logic                               out_valid_q;
	logic signed [slm_pkg::VALUE_W-1:0] out_value_q, out_value_d;
	logic [slm_pkg::STAT_W-1:0]         out_status_q, out_status_d;
	logic                               out_last_q, out_last_d;
	logic                               out_ld;
	logic                               can_out;

	logic                               we_a, we_b;
	logic [AW-1:0]                      raddr_a, raddr_b;
	logic [slm_pkg::VALUE_W-1:0]        rd_a, rd_b;

	logic signed [slm_pkg::VALUE_W-1:0] cmp_x, cmp_y;
	logic                               cmp_lt;

	logic                               a_has, b_has, pick_a, adv;
	logic                               accept;

	slm_ram #(.WIDTH(slm_pkg::VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
		.clk   (clk),
		.we    (we_a),
		.waddr (count_a_q[AW-1:0]),
		.wdata (cmd.value),
		.raddr (raddr_a),
		.rdata (rd_a)
	);

	slm_ram #(.WIDTH(slm_pkg::VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
		.clk   (clk),
		.we    (we_b),
		.waddr (count_b_q[AW-1:0]),
		.wdata (cmd.value),
		.raddr (raddr_b),
		.rdata (rd_b)
	);

	assign can_out   = !out_valid_q || rsp.ready;
	assign cmd.ready = (state_q == slm_pkg::ST_IDLE) && can_out;
	assign accept    = cmd.valid && cmd.ready;

	// shared signed comparator
	assign cmp_lt = cmp_x < cmp_y;

	assign a_has  = ia_q != count_a_q;
	assign b_has  = ib_q != count_b_q;
	assign pick_a = a_has && (!b_has || !cmp_lt);
	assign adv    = (state_q == slm_pkg::ST_MERGE) && can_out;

	always_comb begin
		state_d      = state_q;
		count_a_d    = count_a_q;
		count_b_d    = count_b_q;
		ia_d         = ia_q;
		ib_d         = ib_q;
		last_a_ld    = 1'b0;
		last_b_ld    = 1'b0;
		we_a         = 1'b0;
		we_b         = 1'b0;
		out_ld       = 1'b0;
		out_value_d  = '0;
		out_status_d = slm_pkg::STAT_OK;
		out_last_d   = 1'b1;
		cmp_x        = cmd.value;
		cmp_y        = (cmd.operation == slm_pkg::OP_APPEND_B) ? last_b_q : last_a_q;
		raddr_a      = ia_q[AW-1:0];
		raddr_b      = ib_q[AW-1:0];

		unique case (state_q)
			slm_pkg::ST_IDLE: begin
				if (accept) begin
					priority case (cmd.operation)
						slm_pkg::OP_APPEND_A: begin
							out_ld = 1'b1;
							if (count_a_q != '0 && cmp_lt) begin
								out_status_d = slm_pkg::STAT_ORDER;
							end else if (count_a_q == CW'(LIST_DEPTH)) begin
								out_status_d = slm_pkg::STAT_FULL;
							end else begin
								we_a      = 1'b1;
								last_a_ld = 1'b1;
								count_a_d = count_a_q + CW'(1);
							end
						end
						slm_pkg::OP_APPEND_B: begin
							out_ld = 1'b1;
							if (count_b_q != '0 && cmp_lt) begin
								out_status_d = slm_pkg::STAT_ORDER;
							end else if (count_b_q == CW'(LIST_DEPTH)) begin
								out_status_d = slm_pkg::STAT_FULL;
							end else begin
								we_b      = 1'b1;
								last_b_ld = 1'b1;
								count_b_d = count_b_q + CW'(1);
							end
						end
						slm_pkg::OP_MERGE: begin
							if (count_a_q == '0 && count_b_q == '0) begin
								out_ld       = 1'b1;
								out_status_d = slm_pkg::STAT_EMPTY;
							end else begin
								ia_d    = '0;
								ib_d    = '0;
								state_d = slm_pkg::ST_FETCH;
							end
						end
						default: begin
						end
					endcase
				end
			end
			slm_pkg::ST_FETCH: begin
				state_d = slm_pkg::ST_MERGE;
			end
			slm_pkg::ST_MERGE: begin
				cmp_x = rd_b;
				cmp_y = rd_a;
				if (adv) begin
					out_ld       = 1'b1;
					out_value_d  = pick_a ? rd_a : rd_b;
					out_status_d = slm_pkg::STAT_OK;
					if (pick_a) begin
						ia_d    = ia_q + CW'(1);
						raddr_a = ia_d[AW-1:0];
					end else begin
						ib_d    = ib_q + CW'(1);
						raddr_b = ib_d[AW-1:0];
					end
					out_last_d = (ia_d == count_a_q) && (ib_d == count_b_q);
					if (out_last_d) begin
						count_a_d = '0;
						count_b_d = '0;
						ia_d      = '0;
						ib_d      = '0;
						state_d   = slm_pkg::ST_IDLE;
					end
				end
			end
			default: begin
				state_d = slm_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= slm_pkg::ST_IDLE;
			count_a_q   <= '0;
			count_b_q   <= '0;
			ia_q        <= '0;
			ib_q        <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q   <= state_d;
			count_a_q <= count_a_d;
			count_b_q <= count_b_d;
			ia_q      <= ia_d;
			ib_q      <= ib_d;
			if (out_ld) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (last_a_ld) begin
			last_a_q <= cmd.value;
		end
		if (last_b_ld) begin
			last_b_q <= cmd.value;
		end
		if (out_ld) begin
			out_value_q  <= out_value_d;
			out_status_q <= out_status_d;
			out_last_q   <= out_last_d;
		end
	end

	assign rsp.valid     = out_valid_q;
	assign rsp.value_res = out_value_q;
	assign rsp.status    = out_status_q;
	assign rsp.last      = out_last_q;

endmodule

// ----- rtl/slm_ram.sv -----
// generic single write port ram with registered read
module slm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// ----- rtl/slm_checker.sv -----
// port-level checks for the sorted list merge block, bound to the top level
module slm_checker (
	input logic                               clk,
	input logic                               arst_n,
	input logic                               cmd_valid,
	input logic                               cmd_ready,
	input logic [slm_pkg::OP_W-1:0]           cmd_operation,
	input logic                               rsp_valid,
	input logic                               rsp_ready,
	input logic signed [slm_pkg::VALUE_W-1:0] rsp_value_res,
	input logic [slm_pkg::STAT_W-1:0]         rsp_status,
	input logic                               rsp_last
);

	// stalled result holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_value_res)
			&& $stable(rsp_status) && $stable(rsp_last))
		else $error("stalled result changed");

	// status-only results carry zero and close the item
	a_status_only: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_status != slm_pkg::STAT_OK |-> rsp_value_res == '0 && rsp_last)
		else $error("status result malformed");

	// an append answers in the next cycle with a single result
	a_append_resp: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && (cmd_operation == slm_pkg::OP_APPEND_A
			|| cmd_operation == slm_pkg::OP_APPEND_B) |=> rsp_valid && rsp_last)
		else $error("append result missing");

	// unused operation leaves no result behind
	a_unused_op: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_valid && cmd_ready && cmd_operation != slm_pkg::OP_APPEND_A
			&& cmd_operation != slm_pkg::OP_APPEND_B
			&& cmd_operation != slm_pkg::OP_MERGE |=> !rsp_valid)
		else $error("result after unused operation");

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.cmd_valid     (cmd.valid),
	.cmd_ready     (cmd.ready),
	.cmd_operation (cmd.operation),
	.rsp_valid     (rsp.valid),
	.rsp_ready     (rsp.ready),
	.rsp_value_res (rsp.value_res),
	.rsp_status    (rsp.status),
	.rsp_last      (rsp.last)
);
